[hw/rtl/windowed_peak_to_peak_alert_top_assert.svh]
// Assertion macros used by the alert block checker
`ifndef WINDOWED_PEAK_TO_PEAK_ALERT_TOP_ASSERT_SVH
`define WINDOWED_PEAK_TO_PEAK_ALERT_TOP_ASSERT_SVH

// same-cycle implication, gated by a disable condition
`define WPPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, gated by a disable condition
`define WPPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/wppa_pkg.sv]
package wppa_pkg;

   localparam int STORE_DEPTH_DEFAULT = 96;

   localparam int THRESHOLD_W = 8;
   localparam int SECONDS_W   = 12;
   localparam int STAMP_W     = 32;
   localparam int RATE_W      = 8;
   localparam int HELD_W      = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 8'd30;
   localparam logic [SECONDS_W-1:0]   WINDOW_RESET    = 12'd60;
   localparam logic [SECONDS_W-1:0]   HOLD_RESET      = 12'd60;

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD      = 2'd2;

   localparam logic FUNC_SAMPLE = 1'b0;

   typedef struct packed {
      logic                func;
      logic [STAMP_W-1:0]  time_sec;
      logic [RATE_W-1:0]   raw_bpm;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0]   window_delta;
      logic                alert_on;
      logic                vibrate_pulse;
      logic [HELD_W-1:0]   samples_held;
   } rsp_type;

   typedef struct packed {
      logic [THRESHOLD_W-1:0] delta_threshold;
      logic [SECONDS_W-1:0]   window_seconds;
      logic [SECONDS_W-1:0]   hold_seconds;
   } cfg_type;

   typedef struct packed {
      logic [RATE_W-1:0]  rate;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP_RD,
      ST_DROP_CHK,
      ST_APPEND,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

[hw/rtl/wppa_csr.sv]
module wppa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [wppa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wppa_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output wppa_pkg::cfg_type                   cfg
);
   import wppa_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_THRESHOLD: cfg_in.delta_threshold = csr_wdata[THRESHOLD_W-1:0];
            CSR_WINDOW:    cfg_in.window_seconds  = csr_wdata[SECONDS_W-1:0];
            CSR_HOLD:      cfg_in.hold_seconds    = csr_wdata[SECONDS_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delta_threshold <= THRESHOLD_RESET;
         cfg_ff.window_seconds  <= WINDOW_RESET;
         cfg_ff.hold_seconds    <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/windowed_peak_to_peak_alert_top.sv]
// Channel | Ports                           | Moves
// request | req_valid req_ready req_data    | one sample or time tick
// result  | rsp_valid rsp_ready rsp_data    | one result per request
// config  | csr_valid csr_ready csr_index   | register write, csr_wdata
//
// A tick or zero-rate request goes from idle to the finish state, which loads the
// result register once the output slot is free. A sample drops aged entries (one
// read and check each), then one more check keeps the front entry unless the drops
// emptied the store; the older entries are then streamed from the store for min/max.
// The store is a circular buffer; entries outside the fill count are never used,
// so it needs no clearing after reset. Reset is synchronous and ready on the
// first cycle after. A finished result waits in the output register while the
// next request is taken; a result held there only stalls completion.
module windowed_peak_to_peak_alert_top #(
   parameter int STORE_DEPTH = wppa_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wppa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wppa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wppa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wppa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wppa_pkg::*;

   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW = $clog2(STORE_DEPTH + 1);

   cfg_type cfg;

   wppa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign csr_ready = 1'b1;

   state_type state_ff, state_in;

   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               alert_ff, alert_in;
   logic [STAMP_W-1:0] deadline_ff, deadline_in;
   logic [RATE_W-1:0]  delta_ff, delta_in;
   logic               pulse_ff, pulse_in;
   logic [STAMP_W-1:0] now_ff, now_in;
   logic [RATE_W-1:0]  bpm_ff, bpm_in;
   logic [RATE_W-1:0]  lo_ff, lo_in;
   logic [RATE_W-1:0]  hi_ff, hi_in;
   logic [AW-1:0]      scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]      scan_left_ff, scan_left_in;
   logic               rd_vld_ff, rd_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   entry_type          mem [STORE_DEPTH];
   entry_type          rd_ent_ff;
   logic [AW-1:0]      rd_addr;
   logic               mem_we;
   logic [AW-1:0]      wr_addr;
   entry_type          wr_ent;

   logic               req_fire;
   logic               is_sample;
   logic               too_old;
   logic               store_full;
   logic [AW-1:0]      head_next;
   logic [AW-1:0]      eff_head;
   logic [CW-1:0]      eff_count;
   logic [AW:0]        tail_sum;
   logic [AW-1:0]      tail;
   logic [AW-1:0]      scan_ptr_next;
   logic [RATE_W-1:0]  spread;
   logic               slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign is_sample = (req_data.func == FUNC_SAMPLE) && (req_data.raw_bpm != '0);
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   // aged entry: no age when the stamp is ahead of the current time
   assign too_old = (now_ff >= rd_ent_ff.stamp) &&
                    ((now_ff - rd_ent_ff.stamp) > STAMP_W'(cfg.window_seconds));

   assign store_full = (count_ff == CW'(STORE_DEPTH));
   assign head_next  = (head_ff == AW'(STORE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign eff_head   = store_full ? head_next : head_ff;
   assign eff_count  = store_full ? count_ff - 1'b1 : count_ff;
   assign tail_sum   = (AW+1)'(eff_head) + (AW+1)'(eff_count);
   assign tail       = (tail_sum >= (AW+1)'(STORE_DEPTH)) ?
                       AW'(tail_sum - (AW+1)'(STORE_DEPTH)) : AW'(tail_sum);
   assign scan_ptr_next = (scan_ptr_ff == AW'(STORE_DEPTH - 1)) ? '0 : scan_ptr_ff + 1'b1;
   assign spread     = hi_ff - lo_ff;

   assign rd_addr = (state_ff == ST_SCAN) ? scan_ptr_ff : head_ff;
   assign mem_we  = (state_ff == ST_APPEND);
   assign wr_addr = tail;
   assign wr_ent  = '{rate: bpm_ff, stamp: now_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_ent;
      end
      rd_ent_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = is_sample ? ST_DROP_RD : ST_FINISH;
            end
         end
         ST_DROP_RD: begin
            state_in = (count_ff == '0) ? ST_APPEND : ST_DROP_CHK;
         end
         ST_DROP_CHK: begin
            state_in = too_old ? ST_DROP_RD : ST_APPEND;
         end
         ST_APPEND: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if ((scan_left_ff == '0) && !rd_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      alert_in     = alert_ff;
      deadline_in  = deadline_ff;
      delta_in     = delta_ff;
      pulse_in     = pulse_ff;
      now_in       = now_ff;
      bpm_in       = bpm_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      rd_vld_in    = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in   = req_data.time_sec;
               bpm_in   = req_data.raw_bpm;
               pulse_in = 1'b0;
               // expire the hold before anything else
               if (alert_ff && (req_data.time_sec >= deadline_ff)) begin
                  alert_in = 1'b0;
               end
            end
         end
         ST_DROP_RD: begin
         end
         ST_DROP_CHK: begin
            if (too_old) begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
            end
         end
         ST_APPEND: begin
            // evict the oldest when full, write the new one at the tail
            head_in      = eff_head;
            count_in     = eff_count + 1'b1;
            scan_ptr_in  = eff_head;
            scan_left_in = eff_count;
            lo_in        = bpm_ff;
            hi_in        = bpm_ff;
         end
         ST_SCAN: begin
            if (scan_left_ff != '0) begin
               scan_ptr_in  = scan_ptr_next;
               scan_left_in = scan_left_ff - 1'b1;
               rd_vld_in    = 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_ent_ff.rate < lo_ff) begin
                  lo_in = rd_ent_ff.rate;
               end
               if (rd_ent_ff.rate > hi_ff) begin
                  hi_in = rd_ent_ff.rate;
               end
            end else if (scan_left_ff == '0) begin
               delta_in = spread;
               if (spread >= cfg.delta_threshold) begin
                  pulse_in    = ~alert_ff;
                  alert_in    = 1'b1;
                  deadline_in = now_ff + STAMP_W'(cfg.hold_seconds);
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_in.window_delta  = delta_ff;
               rsp_in.alert_on      = alert_ff;
               rsp_in.vibrate_pulse = pulse_ff;
               rsp_in.samples_held  = HELD_W'(count_ff);
               rsp_valid_in         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         alert_ff     <= 1'b0;
         deadline_ff  <= '0;
         delta_ff     <= '0;
         pulse_ff     <= 1'b0;
         scan_left_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         alert_ff     <= alert_in;
         deadline_ff  <= deadline_in;
         delta_ff     <= delta_in;
         pulse_ff     <= pulse_in;
         scan_left_ff <= scan_left_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      bpm_ff      <= bpm_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      scan_ptr_ff <= scan_ptr_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/wppa_checker.sv]
`include "windowed_peak_to_peak_alert_top_assert.svh"

module wppa_checker #(
   parameter int STORE_DEPTH = wppa_pkg::STORE_DEPTH_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input wppa_pkg::rsp_type   rsp_data
);
   import wppa_pkg::*;

   localparam bit SMALL_STORE = (STORE_DEPTH < 128);

   // a spread can only come from a window of two or more samples
   `WPPA_ASSERT_IMPLY(a_delta_needs_samples, clock, reset,
      rsp_valid && (rsp_data.window_delta != '0) && SMALL_STORE,
      rsp_data.samples_held >= HELD_W'(2), "nonzero delta with fewer than two samples")

   `WPPA_ASSERT_IMPLY(a_pulse_with_alert, clock, reset,
      rsp_valid && rsp_data.vibrate_pulse,
      rsp_data.alert_on, "vibrate pulse without active alert")

   `WPPA_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "stalled result changed or dropped")

   `WPPA_ASSERT_NEXT(a_reset_idle, clock, 1'b0,
      reset,
      !rsp_valid, "result valid right after reset")

endmodule

bind windowed_peak_to_peak_alert_top wppa_checker #(.STORE_DEPTH(STORE_DEPTH)) u_wppa_checker (.*);

[tb/windowed_peak_to_peak_alert_checker.sv]
module windowed_peak_to_peak_alert_checker #(
   parameter int STORE_DEPTH = wppa_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  wppa_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  wppa_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [wppa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wppa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               fail_count,
   output int                               pending_count,
   output int                               checked_count,
   output int                               pulse_count
);
   import wppa_pkg::*;

   entry_type              window_store[$];
   rsp_type                due_results[$];
   logic [THRESHOLD_W-1:0] threshold;
   logic [SECONDS_W-1:0]   window_len;
   logic [SECONDS_W-1:0]   hold_len;
   logic                   alert_active;
   logic [STAMP_W-1:0]     alert_until;
   logic [RATE_W-1:0]      held_delta;
   int                     fails = 0;
   int                     checks = 0;
   int                     pulses = 0;
   rsp_type                want;

   function automatic rsp_type track_window(input req_type r);
      rsp_type             res;
      logic                pulse;
      logic [RATE_W-1:0]   lo;
      logic [RATE_W-1:0]   hi;
      entry_type           fresh;
      pulse = 1'b0;
      if (alert_active && r.time_sec >= alert_until) alert_active = 1'b0;
      if (r.func == FUNC_SAMPLE && r.raw_bpm != '0) begin
         // drop aged samples from the front; a stamp ahead of now has no age
         while (window_store.size() > 0 && r.time_sec >= window_store[0].stamp
                && r.time_sec - window_store[0].stamp > STAMP_W'(window_len))
            void'(window_store.pop_front());
         if (window_store.size() >= STORE_DEPTH) void'(window_store.pop_front());
         fresh.rate  = r.raw_bpm;
         fresh.stamp = r.time_sec;
         window_store.push_back(fresh);
         held_delta = '0;
         if (window_store.size() >= 2) begin
            lo = window_store[0].rate;
            hi = lo;
            foreach (window_store[k]) begin
               if (window_store[k].rate < lo) lo = window_store[k].rate;
               if (window_store[k].rate > hi) hi = window_store[k].rate;
            end
            held_delta = hi - lo;
         end
         if (held_delta >= threshold) begin
            pulse        = !alert_active;
            alert_active = 1'b1;
            alert_until  = r.time_sec + STAMP_W'(hold_len);
         end
      end
      res.window_delta  = held_delta;
      res.alert_on      = alert_active;
      res.vibrate_pulse = pulse;
      res.samples_held  = HELD_W'(window_store.size());
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         window_store.delete();
         due_results.delete();
         threshold    = THRESHOLD_RESET;
         window_len   = WINDOW_RESET;
         hold_len     = HOLD_RESET;
         alert_active = 1'b0;
         alert_until  = '0;
         held_delta   = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               if (fails < 10)
                  $display("unexpected result: delta %0d alert %0b vibrate %0b held %0d",
                           rsp_data.window_delta, rsp_data.alert_on,
                           rsp_data.vibrate_pulse, rsp_data.samples_held);
               fails++;
            end else begin
               want = due_results.pop_front();
               checks++;
               if (rsp_data.window_delta !== want.window_delta ||
                   rsp_data.alert_on !== want.alert_on ||
                   rsp_data.vibrate_pulse !== want.vibrate_pulse ||
                   rsp_data.samples_held !== want.samples_held) begin
                  if (fails < 10) begin
                     $write("result %0d mismatch: expected delta %0d alert %0b ",
                            checks, want.window_delta, want.alert_on);
                     $write("vibrate %0b held %0d, ",
                            want.vibrate_pulse, want.samples_held);
                     $display("got delta %0d alert %0b vibrate %0b held %0d",
                              rsp_data.window_delta, rsp_data.alert_on,
                              rsp_data.vibrate_pulse, rsp_data.samples_held);
                  end
                  fails++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: threshold = csr_wdata[THRESHOLD_W-1:0];
               CSR_WINDOW:    window_len = csr_wdata;
               CSR_HOLD:      hold_len = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            want = track_window(req_data);
            pulses += want.vibrate_pulse;
            due_results.push_back(want);
         end
      end
      fail_count    <= fails;
      pending_count <= due_results.size();
      checked_count <= checks;
      pulse_count   <= pulses;
   end

endmodule

[tb/windowed_peak_to_peak_alert_top_test.sv]
module windowed_peak_to_peak_alert_top_test;
   import wppa_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic                   FUNC_TICK = 1'b1;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int                     fail_count;
   int                     pending_count;
   int                     checked_count;
   int                     pulse_count;
   int                     send_idle_pct = 8;
   int                     recv_idle_pct = 47;
   int                     sent_count = 0;
   int                     write_count = 0;
   logic [STAMP_W-1:0]     now_sec = '0;

   windowed_peak_to_peak_alert_top dut (.*);

   windowed_peak_to_peak_alert_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_request(input logic func, input logic [STAMP_W-1:0] stamp,
                               input logic [RATE_W-1:0] bpm);
      req_type item;
      item.func     = func;
      item.time_sec = stamp;
      item.raw_bpm  = bpm;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // hold off until every predicted result has been taken
   task automatic drain_requests;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      write_count++;
      @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int                level;
      int                swing;
      int                roll;
      logic [RATE_W-1:0] bpm;
      level = 70;
      swing = 10;
      for (int n = 0; n < count; n++) begin
         // shift the rate regime now and then so the spread crosses the threshold
         if (n % 40 == 0) begin
            level = $urandom_range(140, 40);
            swing = $urandom_range(60);
         end
         roll = $urandom_range(99);
         if (roll < 55)      now_sec = now_sec + STAMP_W'($urandom_range(2));
         else if (roll < 80) now_sec = now_sec + STAMP_W'($urandom_range(20, 3));
         else if (roll < 90) now_sec = now_sec + STAMP_W'($urandom_range(300, 40));
         else if (roll < 97) now_sec = now_sec - STAMP_W'($urandom_range(30, 1));
         else                now_sec = now_sec + STAMP_W'($urandom_range(5000, 1000));
         bpm  = RATE_W'(level + $urandom_range(swing));
         roll = $urandom_range(99);
         if (roll < 12)
            send_request(FUNC_TICK, now_sec, RATE_W'($urandom_range(255)));
         else if (roll < 18)
            send_request(FUNC_SAMPLE, now_sec, '0);
         else if (roll < 33)
            send_request(FUNC_SAMPLE, now_sec, RATE_W'($urandom_range(255, 1)));
         else
            send_request(FUNC_SAMPLE, now_sec, bpm);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: threshold 30, window 60, hold 60
      send_request(FUNC_TICK, 32'd0, 8'd0);
      send_request(FUNC_SAMPLE, 32'd0, 8'd255);
      send_request(FUNC_SAMPLE, 32'd1, 8'd1);
      send_request(FUNC_SAMPLE, 32'd2, 8'd0);
      send_request(FUNC_SAMPLE, 32'd3, 8'd128);
      send_request(FUNC_TICK, 32'd63, 8'd0);
      send_request(FUNC_SAMPLE, 32'd63, 8'd128);
      send_request(FUNC_SAMPLE, 32'd40, 8'd200);
      drain_requests();

      // zero threshold, zero window, zero hold; upper threshold bits are dropped
      write_reg(CSR_THRESHOLD, 12'hF00);
      write_reg(CSR_WINDOW, 12'd0);
      write_reg(CSR_HOLD, 12'd0);
      write_reg(CSR_SPARE, 12'hABC);
      send_request(FUNC_SAMPLE, 32'd100, 8'd7);
      send_request(FUNC_SAMPLE, 32'd100, 8'd9);
      send_request(FUNC_TICK, 32'd101, 8'd0);
      drain_requests();

      write_reg(CSR_THRESHOLD, 12'h0FF);
      write_reg(CSR_WINDOW, 12'hFFF);
      write_reg(CSR_HOLD, 12'hFFF);
      send_request(FUNC_SAMPLE, 32'd200, 8'd1);
      send_request(FUNC_SAMPLE, 32'd200, 8'd255);
      drain_requests();

      // deadline past the top of the time range wraps and expires at once
      write_reg(CSR_THRESHOLD, 12'h0FE);
      write_reg(CSR_HOLD, 12'd3600);
      send_request(FUNC_SAMPLE, 32'd201, 8'd1);
      send_request(FUNC_SAMPLE, 32'hFFFF_FFF0, 8'd255);
      send_request(FUNC_SAMPLE, 32'hFFFF_FFF5, 8'd1);
      send_request(FUNC_TICK, 32'hFFFF_FFF6, 8'd0);
      send_request(FUNC_TICK, 32'hFFFF_FFFF, 8'd255);
      drain_requests();

      // long window fills the store and evicts the oldest entries
      write_reg(CSR_THRESHOLD, 12'd120);
      write_reg(CSR_WINDOW, 12'd4095);
      write_reg(CSR_HOLD, 12'd1);
      now_sec = 32'd1000;
      for (int n = 0; n < 110; n++)
         send_request(FUNC_SAMPLE, now_sec, RATE_W'($urandom_range(200, 60)));
      run_random(290);
      drain_requests();

      send_idle_pct = 47;
      recv_idle_pct <= 8;
      write_reg(CSR_THRESHOLD, 12'd40);
      write_reg(CSR_WINDOW, 12'd100);
      write_reg(CSR_HOLD, 12'd20);
      run_random(350);
      drain_requests();

      send_idle_pct = 0;
      recv_idle_pct <= 0;
      write_reg(CSR_THRESHOLD, 12'd0);
      write_reg(CSR_WINDOW, 12'd0);
      write_reg(CSR_HOLD, 12'd0);
      run_random(100);
      drain_requests();

      write_reg(CSR_THRESHOLD, 12'd35);
      write_reg(CSR_WINDOW, 12'd30);
      write_reg(CSR_HOLD, 12'd3600);
      run_random(230);
      drain_requests();

      repeat (20) @(posedge clock);
      $display("Sent %0d requests and %0d register writes under three pacing modes.",
               sent_count, write_count);
      $display("Compared %0d results, %0d of them with an alert onset.",
               checked_count, pulse_count);
      if (fail_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", pending_count);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
